>>> src/particle_impulse_collision_unit_defines.svh
// Assertion macros shared by the particle impulse collision RTL.
`ifndef PARTICLE_IMPULSE_COLLISION_UNIT_DEFINES_SVH
`define PARTICLE_IMPULSE_COLLISION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pic assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pic assertion failed");

`endif

>>> src/pic_pkg.sv
// Types, constants and helper functions of the particle impulse collision unit.
`default_nettype none

package pic_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam int IN_W   = 11 * 32;
  localparam int OUT_W  = 6 * 32;
  localparam int USER_W = 2;
  localparam int ADDR_W = 3;

  localparam int USER_UNCHANGED = 0;
  localparam int USER_SATURATED = 1;

  localparam int RESTITUTION_W = 17;
  localparam logic [RESTITUTION_W-1:0] RESTITUTION_RESET = 17'd62259;
  localparam logic [RESTITUTION_W-1:0] RESTITUTION_MAX   = 17'd65536;
  localparam logic [RESTITUTION_W:0]   ONE_Q16           = 18'd65536;

  // Register index as decoded from paddr[2].
  localparam logic REG_RESTITUTION = 1'b0;

  localparam int SQRT_STEPS = 32;
  localparam int MQ_BITS    = 33;
  localparam int NV_W       = 34;
  localparam int JM_W       = 35;
  localparam int IMP_W      = 36;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [31:0]      ma;
    logic [31:0]      mb;
  } vel_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

>>> src/particle_impulse_collision_unit.sv
// Pipelined impulse collision response for one particle pair per cycle while the output is not stalled.
//
// Usage: one colliding pair is offered on the slave stream (s_tvalid, s_tready,
// s_tdata) and a transfer takes place at each rising edge where s_tvalid and
// s_tready are both high. The corrected velocities leave on the master stream
// (m_tvalid, m_tready, m_tdata, m_tuser), one result transfer per input pair,
// in input order.
// Throughput is one pair per cycle while m_tready does not stall the output;
// every stage of the datapath is a register stage and all stages move together.
// The pipeline depth is set by the 32-step square root, the FRAC_BITS + 1
// step normal division and the 33-step mass division.
// When the receiver stalls, the output register holds its result and the whole
// pipeline freezes; s_tready stays high only while the input stage is empty.
// No transfer is lost or repeated.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// restitution register with 0.95 in Q16 format. The register sits at APB byte
// address 0. The user must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module particle_impulse_collision_unit #(
  parameter int FRAC_BITS = pic_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata, from bit 0 up: rel_pos_x, rel_pos_y, rel_pos_z, a_vel_x, a_vel_y,
  // a_vel_z, b_vel_x, b_vel_y, b_vel_z, a_mass, b_mass (32 bits each).
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pic_pkg::IN_W-1:0]     s_tdata,
  // m_tdata, from bit 0 up: new_a_vel_x, new_a_vel_y, new_a_vel_z,
  // new_b_vel_x, new_b_vel_y, new_b_vel_z (32 bits each).
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pic_pkg::OUT_W-1:0]    m_tdata,
  // m_tuser, from bit 0 up: unchanged, saturated.
  output logic [pic_pkg::USER_W-1:0]   m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pic_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pic_pkg::*;
  `include "particle_impulse_collision_unit_defines.svh"

  localparam int QN   = FRAC_BITS + 1;   // normal quotient bits
  localparam int NW   = FRAC_BITS + 2;   // signed normal component
  localparam int DNW  = 32 + FRAC_BITS;  // normal division numerator
  localparam int PRW  = NW + 33;         // n * r product
  localparam int PW   = FRAC_BITS + 37;  // normal speed sum
  localparam int IFW  = NW + JM_W + 1;   // n * jm product
  localparam int NUMW = 35 + FRAC_BITS;  // mass division numerator
  localparam int DMW  = (NUMW > 64) ? NUMW : 64;
  localparam int QMW  = MQ_BITS + 1;
  localparam int SW   = MQ_BITS + 2;
  localparam int L    = 2 + (SQRT_STEPS + 1) + (QN + 1) + 8 + (MQ_BITS + 1);
  localparam int V_NQ = 3 + SQRT_STEPS + QN;
  localparam logic [QN-1:0] Q_ONE = QN'(1) << FRAC_BITS;

  // ---------------------------------------------------------------- config
  logic [RESTITUTION_W-1:0] restitution;
  logic [RESTITUTION_W:0]   ef;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESTITUTION) ? 32'(restitution) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= RESTITUTION_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RESTITUTION) begin
      restitution <= pwdata[RESTITUTION_W-1:0];
    end
  end

  // One plus the restitution, with values above one acting as one.
  assign ef = ONE_Q16 + ((restitution > RESTITUTION_MAX) ? {1'b0, RESTITUTION_MAX}
                                                        : {1'b0, restitution});

  // ---------------------------------------------------------- flow control
  logic         advance;
  logic [L-1:0] vld;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance || !vld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {advance ? vld[L-2:0] : vld[L-1:1], s_tready ? s_tvalid : vld[0]};
    end
  end

  // ------------------------------------------------------------ input stage
  logic [2:0][31:0] d_in;
  vel_t             vel_in;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < 3; i++) begin
        d_in[i]      <= s_tdata[32*i +: 32];
        vel_in.va[i] <= s_tdata[32*(3+i) +: 32];
        vel_in.vb[i] <= s_tdata[32*(6+i) +: 32];
      end
      vel_in.ma <= s_tdata[32*9 +: 32];
      vel_in.mb <= s_tdata[32*10 +: 32];
    end
  end

  // --------------------------------------------------------------- squares
  logic [2:0][63:0] sq;
  logic [2:0][31:0] d_sq;
  vel_t             vel_sq;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= 64'(mag32(d_in[i])) * 64'(mag32(d_in[i]));
      end
      d_sq   <= d_in;
      vel_sq <= vel_in;
    end
  end

  // ----------------------------------------------------------- square root
  // Entry 0 holds the sum of squares; each later entry is one restoring step.
  logic [63:0]      sr_rem  [0:SQRT_STEPS];
  logic [63:0]      sr_root [0:SQRT_STEPS];
  logic [2:0][31:0] sr_d    [0:SQRT_STEPS];
  vel_t             sr_vel  [0:SQRT_STEPS];
  logic             sr_zero [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      sr_rem[0]  <= sq[0] + sq[1] + sq[2];
      sr_root[0] <= '0;
      sr_d[0]    <= d_sq;
      sr_vel[0]  <= vel_sq;
      sr_zero[0] <= (d_sq == '0);
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    assign trial = sr_root[k] + SQ_BIT;
    assign take  = (sr_rem[k] >= trial);

    always_ff @(posedge clk) begin
      if (advance) begin
        sr_rem[k+1]  <= take ? (sr_rem[k] - trial) : sr_rem[k];
        sr_root[k+1] <= take ? ((sr_root[k] >> 1) + SQ_BIT) : (sr_root[k] >> 1);
        sr_d[k+1]    <= sr_d[k];
        sr_vel[k+1]  <= sr_vel[k];
        sr_zero[k+1] <= sr_zero[k];
      end
    end
  end

  // ------------------------------------------------------ normal division
  logic [2:0][DNW-1:0] nd_rem  [0:QN];
  logic [2:0][QN-1:0]  nd_q    [0:QN];
  logic [2:0]          nd_neg  [0:QN];
  logic [31:0]         nd_m    [0:QN];
  vel_t                nd_vel  [0:QN];
  logic                nd_zero [0:QN];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        nd_rem[0][i] <= {mag32(sr_d[SQRT_STEPS][i]), {FRAC_BITS{1'b0}}};
        nd_neg[0][i] <= sr_d[SQRT_STEPS][i][31];
      end
      nd_q[0]    <= '0;
      nd_m[0]    <= sr_root[SQRT_STEPS][31:0];
      nd_vel[0]  <= sr_vel[SQRT_STEPS];
      nd_zero[0] <= sr_zero[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < QN; j++) begin : g_ndiv
    localparam int B = FRAC_BITS - j;
    logic [DNW-1:0] trial;
    logic [2:0]     take;

    assign trial = DNW'(nd_m[j]) << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign take[i] = (nd_rem[j][i] >= trial);
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        for (int i = 0; i < 3; i++) begin
          nd_rem[j+1][i] <= take[i] ? (nd_rem[j][i] - trial) : nd_rem[j][i];
          nd_q[j+1][i]   <= nd_q[j][i] | (QN'(take[i]) << B);
        end
        nd_neg[j+1]  <= nd_neg[j];
        nd_m[j+1]    <= nd_m[j];
        nd_vel[j+1]  <= nd_vel[j];
        nd_zero[j+1] <= nd_zero[j];
      end
    end
  end

  // ------------------------------------------ normal, relative velocity
  logic signed [NW-1:0] n_n [3];
  logic signed [32:0]   r_n [3];
  vel_t                 vel_n;
  logic                 zero_n;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        n_n[i] <= nd_neg[QN][i] ? (~{1'b0, nd_q[QN][i]} + NW'(1)) : {1'b0, nd_q[QN][i]};
        r_n[i] <= $signed({nd_vel[QN].va[i][31], nd_vel[QN].va[i]})
                - $signed({nd_vel[QN].vb[i][31], nd_vel[QN].vb[i]});
      end
      vel_n  <= nd_vel[QN];
      zero_n <= nd_zero[QN];
    end
  end

  // ------------------------------------------------ normal speed products
  logic signed [PRW-1:0] pr_p1 [3];
  logic signed [NW-1:0]  n_p1  [3];
  vel_t                  vel_p1;
  logic                  zero_p1;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        pr_p1[i] <= PRW'(n_n[i]) * PRW'(r_n[i]);
        n_p1[i]  <= n_n[i];
      end
      vel_p1  <= vel_n;
      zero_p1 <= zero_n;
    end
  end

  logic signed [PW-1:0] p_p2;
  logic signed [NW-1:0] n_p2 [3];
  vel_t                 vel_p2;
  logic                 zero_p2;

  always_ff @(posedge clk) begin
    if (advance) begin
      p_p2    <= PW'(pr_p1[0]) + PW'(pr_p1[1]) + PW'(pr_p1[2]);
      n_p2    <= n_p1;
      vel_p2  <= vel_p1;
      zero_p2 <= zero_p1;
    end
  end

  // A separating pair (positive normal speed) or a zero separation passes.
  logic signed [PW-1:0] vn;
  logic signed [PW-1:0] vn_neg;
  logic [NV_W-1:0]      nv_p3;
  logic signed [NW-1:0] n_p3 [3];
  vel_t                 vel_p3;
  logic                 unch_p3;

  assign vn     = p_p2 >>> FRAC_BITS;
  assign vn_neg = -vn;

  always_ff @(posedge clk) begin
    if (advance) begin
      nv_p3   <= vn_neg[NV_W-1:0];
      unch_p3 <= zero_p2 || (!p_p2[PW-1] && (p_p2 != '0));
      n_p3    <= n_p2;
      vel_p3  <= vel_p2;
    end
  end

  // ------------------------------------------- impulse magnitude, two halves
  logic [RESTITUTION_W+17:0] jl_j1;
  logic [RESTITUTION_W+17:0] jh_j1;
  logic signed [NW-1:0]      n_j1 [3];
  vel_t                      vel_j1;
  logic                      unch_j1;

  always_ff @(posedge clk) begin
    if (advance) begin
      jl_j1   <= ef * nv_p3[16:0];
      jh_j1   <= ef * nv_p3[NV_W-1:17];
      n_j1    <= n_p3;
      vel_j1  <= vel_p3;
      unch_j1 <= unch_p3;
    end
  end

  logic [RESTITUTION_W+34:0] jsum;
  logic [JM_W-1:0]           jm_j2;
  logic signed [NW-1:0]      n_j2 [3];
  vel_t                      vel_j2;
  logic                      unch_j2;

  assign jsum = {jh_j1, 17'b0} + {17'b0, jl_j1};

  always_ff @(posedge clk) begin
    if (advance) begin
      jm_j2   <= jsum[16 +: JM_W];
      n_j2    <= n_j1;
      vel_j2  <= vel_j1;
      unch_j2 <= unch_j1;
    end
  end

  // --------------------------------------------- impulse vector, two halves
  logic signed [NW+18:0] il_i1 [3];
  logic signed [NW+17:0] ih_i1 [3];
  vel_t                  vel_i1;
  logic                  unch_i1;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        il_i1[i] <= n_j2[i] * $signed({1'b0, jm_j2[17:0]});
        ih_i1[i] <= n_j2[i] * $signed({1'b0, jm_j2[JM_W-1:18]});
      end
      vel_i1  <= vel_j2;
      unch_i1 <= unch_j2;
    end
  end

  logic signed [IFW-1:0]   ifull [3];
  logic signed [IMP_W-1:0] imp_i2 [3];
  vel_t                    vel_i2;
  logic                    unch_i2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ifull[i] = (IFW'(ih_i1[i]) <<< 18) + IFW'(il_i1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        imp_i2[i] <= IMP_W'(ifull[i] >>> FRAC_BITS);
      end
      vel_i2  <= vel_i1;
      unch_i2 <= unch_i1;
    end
  end

  // -------------------------------------------------------- mass division
  // Lanes 0..2 divide by a_mass, lanes 3..5 by b_mass. A quotient of 2^33 or
  // more always saturates, so it is flagged instead of computed.
  logic [5:0][NUMW-1:0]  dz_num;
  logic [5:0][31:0]      dz_mass;
  logic [5:0]            dz_neg;
  logic signed [IMP_W-1:0] dz_imp [6];
  logic signed [IMP_W-1:0] dz_abs [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dz_imp[i]    = imp_i2[i];
      dz_imp[i+3]  = imp_i2[i];
      dz_mass[i]   = vel_i2.ma;
      dz_mass[i+3] = vel_i2.mb;
    end
    for (int l = 0; l < 6; l++) begin
      dz_neg[l]  = dz_imp[l][IMP_W-1];
      dz_abs[l]  = dz_neg[l] ? -dz_imp[l] : dz_imp[l];
      dz_num[l]  = {dz_abs[l][IMP_W-2:0], {FRAC_BITS{1'b0}}};
    end
  end

  logic [5:0][DMW-1:0]     md_rem  [0:MQ_BITS];
  logic [5:0][MQ_BITS-1:0] md_q    [0:MQ_BITS];
  logic [5:0]              md_neg  [0:MQ_BITS];
  logic [5:0]              md_ovf  [0:MQ_BITS];
  logic [5:0]              md_mz   [0:MQ_BITS];
  vel_t                    md_vel  [0:MQ_BITS];
  logic                    md_unch [0:MQ_BITS];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int l = 0; l < 6; l++) begin
        md_rem[0][l] <= DMW'(dz_num[l]);
        md_ovf[0][l] <= ((dz_num[l] >> MQ_BITS) >= NUMW'(dz_mass[l]));
        md_mz[0][l]  <= (dz_mass[l] == '0);
      end
      md_neg[0]  <= dz_neg;
      md_q[0]    <= '0;
      md_vel[0]  <= vel_i2;
      md_unch[0] <= unch_i2;
    end
  end

  for (genvar j = 0; j < MQ_BITS; j++) begin : g_mdiv
    localparam int B = MQ_BITS - 1 - j;
    logic [5:0][DMW-1:0] trial;
    logic [5:0]          take;

    for (genvar l = 0; l < 6; l++) begin : g_lane
      if (l < 3) begin : g_a
        assign trial[l] = DMW'(md_vel[j].ma) << B;
      end else begin : g_b
        assign trial[l] = DMW'(md_vel[j].mb) << B;
      end
      assign take[l] = (md_rem[j][l] >= trial[l]);
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        for (int l = 0; l < 6; l++) begin
          md_rem[j+1][l] <= take[l] ? (md_rem[j][l] - trial[l]) : md_rem[j][l];
          md_q[j+1][l]   <= md_q[j][l] | (MQ_BITS'(take[l]) << B);
        end
        md_neg[j+1]  <= md_neg[j];
        md_ovf[j+1]  <= md_ovf[j];
        md_mz[j+1]   <= md_mz[j];
        md_vel[j+1]  <= md_vel[j];
        md_unch[j+1] <= md_unch[j];
      end
    end
  end

  // ------------------------------------------- velocity update, saturation
  logic [5:0][QMW-1:0]  f_qm;
  logic signed [SW-1:0] f_delta [6];
  logic signed [SW-1:0] f_v     [6];
  logic signed [SW-1:0] f_sum   [6];
  logic [5:0]           f_hi;
  logic [5:0]           f_lo;
  logic [OUT_W-1:0]     data_next;
  logic [USER_W-1:0]    user_next;

  always_comb begin
    data_next = '0;
    user_next = '0;
    for (int i = 0; i < 3; i++) begin
      f_v[i]   = SW'($signed(md_vel[MQ_BITS].va[i]));
      f_v[i+3] = SW'($signed(md_vel[MQ_BITS].vb[i]));
    end
    for (int l = 0; l < 6; l++) begin
      if (md_mz[MQ_BITS][l]) begin
        f_qm[l] = '0;
      end else if (md_ovf[MQ_BITS][l]) begin
        f_qm[l] = QMW'(1) << MQ_BITS;
      end else begin
        f_qm[l] = {1'b0, md_q[MQ_BITS][l]};
      end
      f_delta[l] = md_neg[MQ_BITS][l] ? -$signed(SW'(f_qm[l])) : $signed(SW'(f_qm[l]));
      f_sum[l]   = (l < 3) ? (f_v[l] + f_delta[l]) : (f_v[l] - f_delta[l]);
      f_hi[l]    = !f_sum[l][SW-1] && (f_sum[l][SW-2:31] != '0);
      f_lo[l]    = f_sum[l][SW-1] && (f_sum[l][SW-2:31] != '1);
      if (f_hi[l]) begin
        data_next[32*l +: 32] = WORD_MAX;
      end else if (f_lo[l]) begin
        data_next[32*l +: 32] = WORD_MIN;
      end else begin
        data_next[32*l +: 32] = f_sum[l][31:0];
      end
    end
    user_next[USER_SATURATED] = |(f_hi | f_lo);
    if (md_unch[MQ_BITS]) begin
      data_next = {md_vel[MQ_BITS].vb, md_vel[MQ_BITS].va};
      user_next = '0;
      user_next[USER_UNCHANGED] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= data_next;
      m_tuser <= user_next;
    end
  end

  // ------------------------------------------------------------ assertions
  logic n_in_range;

  assign n_in_range = (nd_q[QN][0] <= Q_ONE) && (nd_q[QN][1] <= Q_ONE)
                   && (nd_q[QN][2] <= Q_ONE);

  `PIC_ASSERT_IMPL(a_flags_exclusive, m_tvalid, !(&m_tuser))
  `PIC_ASSERT_IMPL(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready && vld[0])
  `PIC_ASSERT_NEXT(a_pipe_frozen, !advance, $stable(vld[L-1:1]))
  `PIC_ASSERT_IMPL(a_normal_bound, vld[V_NQ] && !nd_zero[QN], n_in_range)

endmodule

`default_nettype wire
